[design/svrs_pkg.sv]
// Shared types, codes and helpers for the servo recipe sequencer.
`default_nettype none
package svrs_pkg;

  localparam int POS_W    = 5;
  localparam int DELAY_W  = 8;
  localparam int WAIT_W   = 13;
  localparam int WORD_W   = 8;
  localparam int LED_W    = 8;
  localparam int ADDR_X_W = 9;
  localparam int STEP_W   = 3;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;
  localparam logic [1:0] CMD_PAUSE = 2'd3;

  localparam logic [2:0] OP_END   = 3'd0;
  localparam logic [2:0] OP_MOVE  = 3'd1;
  localparam logic [2:0] OP_WAIT  = 3'd2;
  localparam logic [2:0] OP_RMOVE = 3'd3;
  localparam logic [2:0] OP_LOOP  = 3'd4;
  localparam logic [2:0] OP_ENDLP = 3'd5;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_WORD = 2'd1;
  localparam logic [1:0] ERR_NEST = 2'd2;

  localparam logic [1:0] CFG_MAX_POS    = 2'd0;
  localparam logic [1:0] CFG_MOVE_DELAY = 2'd1;
  localparam logic [1:0] CFG_LED_EN     = 2'd2;

  localparam logic [LED_W-1:0] LED_ALL     = 8'hFF;
  localparam logic [LED_W-1:0] LED_ERR_WRD = 8'h80;
  localparam logic [LED_W-1:0] LED_ERR_NST = 8'h40;
  localparam logic [LED_W-1:0] LED_ENDED   = 8'h20;
  localparam logic [LED_W-1:0] LED_PAUSED  = 8'h10;

  typedef enum logic [1:0] {
    MODE_PAUSED  = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_ENDED   = 2'd2,
    MODE_ERROR   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [WAIT_W-1:0] a;
    logic [WAIT_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [WAIT_W-1:0] res;
    logic              carry;
  } alu_rsp_t;

  function automatic logic [LED_W-1:0] led_byte(input logic enable, input logic pc_odd,
                                                input mode_t mode, input logic [1:0] code);
    logic [LED_W-1:0] p;
    p = pc_odd ? '0 : LED_ALL;
    case (mode)
      MODE_ERROR: begin
        if (code == ERR_WORD) begin
          p = p & ~LED_ERR_WRD;
        end else if (code == ERR_NEST) begin
          p = p & ~LED_ERR_NST;
        end
      end
      MODE_ENDED:  p = p & ~LED_ENDED;
      MODE_PAUSED: p = p & ~LED_PAUSED;
      default:     p = p;
    endcase
    return enable ? p : '0;
  endfunction

endpackage
`default_nettype wire

[design/servo_recipe_sequencer_top.sv]
// Servo recipe sequencer: command decode, recipe execution sequencer and state.
//
//   channel  | ports                                   | timing
//   ---------+-----------------------------------------+--------------------------
//   command  | start, busy, cmd, load_addr, load_word   | beat taken: start && !busy
//   result   | done, position, run_state, error_kind,   | one cycle, no stall
//            | program_counter, led_pattern             |
//   config   | cfg_we, cfg_index, cfg_data             | write when cfg_we is high
//
// Load, run, pause, blocked ticks, countdown ticks, out-of-range moves and words
// other than moves and waits keep busy high through S_DISPATCH and S_DONE, done in S_DONE.
// A wait word passes S_DISPATCH, S_MUL, S_DONE; a move adds S_DIFF_A (and S_DIFF_B when
// below target), a clamped move S_SUM; S_MUL is five shift-add steps on the shared adder.
// Reset is synchronous; it clears the sequencer and state but not the recipe memory.
// The receiver cannot stall, so a result is shown for exactly one cycle.
`default_nettype none
module servo_recipe_sequencer_top #(
  parameter int RECIPE_DEPTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    cmd,
  input  wire logic [4:0]                    load_addr,
  input  wire logic [svrs_pkg::WORD_W-1:0]   load_word,
  output logic                               done,
  output logic [svrs_pkg::POS_W-1:0]         position,
  output logic [1:0]                         run_state,
  output logic [1:0]                         error_kind,
  output logic [4:0]                         program_counter,
  output logic [svrs_pkg::LED_W-1:0]         led_pattern,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [svrs_pkg::DELAY_W-1:0]  cfg_data
);
  import svrs_pkg::*;

  localparam int AW = $clog2(RECIPE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SUM,
    S_DIFF_A,
    S_DIFF_B,
    S_MUL,
    S_DONE
  } state_t;

  state_t             state;
  logic [1:0]         cmd_q;
  logic [4:0]         addr_q;
  logic [WORD_W-1:0]  word_q;
  logic [LED_W-1:0]   led_q;
  logic [AW-1:0]      pc_reg;
  logic [WAIT_W-1:0]  wait_count;
  logic [AW-1:0]      loop_start_addr;
  logic [POS_W-1:0]   loop_remaining;
  logic [POS_W-1:0]   pos_reg;
  logic               error_flag;
  logic [1:0]         error_code_reg;
  logic               done_flag;
  mode_t              mode_reg;
  logic [POS_W-1:0]   target;
  logic [POS_W-1:0]   travel;
  logic [STEP_W-1:0]  step;
  logic [POS_W-1:0]   max_position;
  logic [DELAY_W-1:0] move_delay;
  logic               led_enable;

  logic [WORD_W-1:0]   rdata;
  logic [2:0]          opcode;
  logic [POS_W-1:0]    prm;
  logic [ADDR_X_W-1:0] addr_ext;
  logic [ADDR_X_W-1:0] pc_ext;
  logic                addr_ok;
  logic                store_we;
  logic [AW-1:0]       pc_next;
  logic [POS_W:0]      sum_x;
  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;

  assign opcode   = rdata[WORD_W-1:POS_W];
  assign prm      = rdata[POS_W-1:0];
  assign addr_ext = ADDR_X_W'(addr_q);
  assign addr_ok  = addr_ext < ADDR_X_W'(RECIPE_DEPTH);
  assign store_we = (state == S_DISPATCH) && (cmd_q == CMD_LOAD) && addr_ok;
  assign pc_next  = (pc_reg == AW'(RECIPE_DEPTH - 1)) ? '0 : pc_reg + AW'(1);
  assign sum_x    = alu_rsp.res[POS_W:0];

  svrs_store #(
    .DEPTH (RECIPE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (addr_ext[AW-1:0]),
    .wdata (word_q),
    .raddr (pc_reg),
    .rdata (rdata)
  );

  always_comb begin
    alu_req = '0;
    case (state)
      S_DISPATCH: begin
        alu_req.a   = wait_count;
        alu_req.b   = WAIT_W'(1);
        alu_req.sub = 1'b1;
      end
      S_SUM: begin
        alu_req.a = WAIT_W'(pos_reg);
        alu_req.b = WAIT_W'(target);
      end
      S_DIFF_A: begin
        alu_req.a   = WAIT_W'(pos_reg);
        alu_req.b   = WAIT_W'(target);
        alu_req.sub = 1'b1;
      end
      S_DIFF_B: begin
        alu_req.a   = WAIT_W'(target);
        alu_req.b   = WAIT_W'(pos_reg);
        alu_req.sub = 1'b1;
      end
      S_MUL: begin
        alu_req.a = wait_count;
        alu_req.b = WAIT_W'(move_delay) << step;
      end
      default: alu_req = '0;
    endcase
  end

  svrs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_position <= POS_W'(5);
      move_delay   <= DELAY_W'(2);
      led_enable   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_POS:    max_position <= cfg_data[POS_W-1:0];
        CFG_MOVE_DELAY: move_delay   <= cfg_data;
        CFG_LED_EN:     led_enable   <= cfg_data[0];
        default:        max_position <= max_position;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      pc_reg          <= '0;
      wait_count      <= '0;
      loop_start_addr <= '0;
      loop_remaining  <= '0;
      pos_reg         <= '0;
      error_flag      <= 1'b0;
      error_code_reg  <= ERR_NONE;
      done_flag       <= 1'b0;
      mode_reg        <= MODE_PAUSED;
      step            <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q  <= cmd;
            addr_q <= load_addr;
            word_q <= load_word;
            led_q  <= led_byte(led_enable, pc_reg[0], mode_reg, error_code_reg);
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state <= S_DONE;
          step  <= '0;
          case (cmd_q)
            CMD_RUN:   mode_reg <= MODE_RUNNING;
            CMD_PAUSE: mode_reg <= MODE_PAUSED;
            CMD_TICK: begin
              if (error_flag || done_flag || mode_reg != MODE_RUNNING) begin
                if (error_flag) begin
                  mode_reg <= MODE_ERROR;
                end else if (done_flag) begin
                  mode_reg <= MODE_ENDED;
                end
              end else if (wait_count != '0) begin
                wait_count <= alu_rsp.res;
              end else begin
                case (opcode)
                  OP_END: done_flag <= 1'b1;
                  OP_MOVE, OP_RMOVE: begin
                    if (prm > max_position) begin
                      error_flag     <= 1'b1;
                      error_code_reg <= ERR_WORD;
                    end else begin
                      target <= prm;
                      state  <= (opcode == OP_MOVE) ? S_DIFF_A : S_SUM;
                    end
                  end
                  OP_WAIT: begin
                    target <= pos_reg;
                    travel <= prm;
                    state  <= S_MUL;
                  end
                  OP_LOOP: begin
                    if (loop_remaining != '0) begin
                      error_flag     <= 1'b1;
                      error_code_reg <= ERR_NEST;
                    end else begin
                      loop_start_addr <= pc_next;
                      loop_remaining  <= prm;
                      pc_reg          <= pc_next;
                    end
                  end
                  OP_ENDLP: begin
                    if (loop_remaining != '0) begin
                      pc_reg         <= loop_start_addr;
                      loop_remaining <= loop_remaining - POS_W'(1);
                    end else begin
                      pc_reg <= pc_next;
                    end
                  end
                  default: begin
                    error_flag     <= 1'b1;
                    error_code_reg <= ERR_WORD;
                  end
                endcase
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_SUM: begin
          target <= (sum_x > {1'b0, max_position}) ? max_position : sum_x[POS_W-1:0];
          state  <= S_DIFF_A;
        end
        S_DIFF_A: begin
          if (alu_rsp.carry) begin
            travel <= alu_rsp.res[POS_W-1:0];
            state  <= S_MUL;
          end else begin
            state <= S_DIFF_B;
          end
        end
        S_DIFF_B: begin
          travel <= alu_rsp.res[POS_W-1:0];
          state  <= S_MUL;
        end
        S_MUL: begin
          if (travel[step]) begin
            wait_count <= alu_rsp.res;
          end
          step <= step + STEP_W'(1);
          if (step == STEP_W'(POS_W - 1)) begin
            pos_reg <= target;
            pc_reg  <= pc_next;
            state   <= S_DONE;
          end
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pc_ext          = ADDR_X_W'(pc_reg);
  assign busy            = (state != S_IDLE);
  assign done            = (state == S_DONE);
  assign position        = pos_reg;
  assign run_state       = mode_reg;
  assign error_kind      = error_code_reg;
  assign program_counter = pc_ext[4:0];
  assign led_pattern     = led_q;

endmodule
`default_nettype wire

[design/svrs_store.sv]
// Recipe word memory with one write port and one registered read port.
`default_nettype none
module svrs_store #(
  parameter int DEPTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr,
  input  wire logic [svrs_pkg::WORD_W-1:0]  wdata,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr,
  output logic      [svrs_pkg::WORD_W-1:0]  rdata
);
  import svrs_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/svrs_alu.sv]
// Shared add and subtract unit used by the countdown, move and multiply steps of the sequencer.
`default_nettype none
module svrs_alu (
  input  wire svrs_pkg::alu_req_t req,
  output svrs_pkg::alu_rsp_t      rsp
);
  import svrs_pkg::*;

  logic [WAIT_W:0] sum;

  always_comb begin
    sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{WAIT_W{1'b0}}, req.sub};
    rsp.res   = sum[WAIT_W-1:0];
    rsp.carry = sum[WAIT_W];
  end

endmodule
`default_nettype wire
